### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent holds in the cycle after antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### hw/rtl/i2d_pkg.sv
// ---------------------------------------------------------------------------
// i2d_pkg
// Shared types and constants for the integer to decimal text converter.
// ---------------------------------------------------------------------------
package i2d_pkg;

  localparam int VALUE_W    = 64;
  localparam int BIT_CNT_W  = 6;   // counts the 64 input bits
  localparam int NUM_DIGITS = 19;  // 2**63 has 19 decimal digits
  localparam int DIG_CNT_W  = 5;   // holds 0..NUM_DIGITS
  localparam int CHAR_W     = 6;

  localparam logic [CHAR_W-1:0] CODE_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CODE_NINE  = 6'd57;
  localparam logic [CHAR_W-1:0] CODE_MINUS = 6'd45;

  typedef logic [3:0] bcd_t;

  // Per-cycle command broadcast to every digit cell.
  typedef struct packed {
    logic clear;      // zero the digit
    logic shift_bin;  // add-3 correct, shift one binary bit in
    logic shift_dig;  // take the lower neighbor's digit
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_t;

endpackage

### hw/rtl/i2d_cell.sv
// ---------------------------------------------------------------------------
// i2d_cell
// One BCD digit of the shift-and-add-3 chain.
// ---------------------------------------------------------------------------
module i2d_cell (
  input  logic                clk,
  input  i2d_pkg::cell_ctrl_t ctrl,
  input  logic                bit_in,
  input  i2d_pkg::bcd_t       digit_in,
  output logic                carry_out,
  output i2d_pkg::bcd_t       digit
);
  import i2d_pkg::*;

  bcd_t dig_r;
  bcd_t dig_nxt;
  bcd_t corr;

  // add 3 when >= 5 so the following doubling carries at ten
  assign corr      = (dig_r >= 4'd5) ? (dig_r + 4'd3) : dig_r;
  assign carry_out = corr[3];
  assign digit     = dig_r;

  always_comb begin
    dig_nxt = dig_r;
    priority if (ctrl.clear) begin
      dig_nxt = 4'd0;
    end else if (ctrl.shift_bin) begin
      dig_nxt = {corr[2:0], bit_in};
    end else if (ctrl.shift_dig) begin
      dig_nxt = digit_in;
    end
  end

  always_ff @(posedge clk) begin
    dig_r <= dig_nxt;
  end

endmodule

### hw/rtl/i2d_chain.sv
// ---------------------------------------------------------------------------
// i2d_chain
// Row of digit cells; cell 0 is least significant, the top cell is read out.
// ---------------------------------------------------------------------------
module i2d_chain (
  input  logic                clk,
  input  i2d_pkg::cell_ctrl_t ctrl,
  input  logic                bit_in,
  output i2d_pkg::bcd_t       top_digit
);
  import i2d_pkg::*;

  logic [NUM_DIGITS-1:0] carry;
  bcd_t                  digs [NUM_DIGITS];

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    logic cin;
    bcd_t din;
    if (i == 0) begin : g_first
      assign cin = bit_in;
      assign din = 4'd0;
    end else begin : g_rest
      assign cin = carry[i-1];
      assign din = digs[i-1];
    end
    i2d_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .bit_in    (cin),
      .digit_in  (din),
      .carry_out (carry[i]),
      .digit     (digs[i])
    );
  end

  assign top_digit = digs[NUM_DIGITS-1];

endmodule

### hw/rtl/int64_to_decimal_ascii.sv
// ---------------------------------------------------------------------------
// int64_to_decimal_ascii
// Signed 64-bit integer to decimal ASCII text, one character per item.
// ---------------------------------------------------------------------------
// One input item (a signed 64-bit value) produces 1 to 20 output items: a
// minus sign for negative values, then the decimal digits, most significant
// first, without leading zeros; the final character has out_last set. The
// magnitude is converted by a row of 19 BCD cells doing shift-and-add-3, one
// binary bit per cycle. Leading zeros are then dropped by shifting the row one
// digit per cycle, and a last step settles on the first digit to send. The
// characters leave one per cycle while out_ready is held, from the top cell
// through an output register. Dropped zeros plus sent digits always total 19.
// One item is in work at a time; in_ready rises again as soon as the last
// character has been loaded into the output register, even if it has not been
// taken yet.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module int64_to_decimal_ascii (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [63:0]           in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [i2d_pkg::CHAR_W-1:0]   out_char_code,
  output logic                         out_last
);
  import i2d_pkg::*;

  state_t                 state_r,   state_nxt;
  logic [VALUE_W-1:0]     mag_r,     mag_nxt;     // magnitude, MSB shifted out
  logic                   neg_r,     neg_nxt;
  logic [BIT_CNT_W-1:0]   cnt_r,     cnt_nxt;     // input bits consumed
  logic [DIG_CNT_W-1:0]   ndig_r,    ndig_nxt;    // digits left in the row
  logic                   ovalid_r,  ovalid_nxt;
  logic [CHAR_W-1:0]      ochar_r,   ochar_nxt;
  logic                   olast_r,   olast_nxt;

  cell_ctrl_t             cell_ctrl;
  bcd_t                   top_digit;
  logic                   slot_free;

  // output register may be refilled when empty or being drained this cycle
  assign slot_free = !ovalid_r || out_ready;

  i2d_chain u_chain (
    .clk       (clk),
    .ctrl      (cell_ctrl),
    .bit_in    (mag_r[VALUE_W-1]),
    .top_digit (top_digit)
  );

  always_comb begin
    state_nxt  = state_r;
    mag_nxt    = mag_r;
    neg_nxt    = neg_r;
    cnt_nxt    = cnt_r;
    ndig_nxt   = ndig_r;
    ovalid_nxt = ovalid_r && !out_ready;
    ochar_nxt  = ochar_r;
    olast_nxt  = olast_r;
    cell_ctrl  = '0;
    in_ready   = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          neg_nxt         = in_value[VALUE_W-1];
          // two's complement negate; the most negative value stays exact
          mag_nxt         = in_value[VALUE_W-1] ? (VALUE_W'(0) - $unsigned(in_value))
                                                : $unsigned(in_value);
          cnt_nxt         = '0;
          cell_ctrl.clear = 1'b1;
          state_nxt       = ST_CONV;
        end
      end

      ST_CONV: begin
        cell_ctrl.shift_bin = 1'b1;
        mag_nxt             = {mag_r[VALUE_W-2:0], 1'b0};
        cnt_nxt             = cnt_r + 1'b1;
        if (cnt_r == '1) begin
          ndig_nxt  = DIG_CNT_W'(NUM_DIGITS);
          state_nxt = ST_SKIP;
        end
      end

      ST_SKIP: begin
        // drop leading zeros, always keep at least one digit
        if (top_digit == 4'd0 && ndig_r != DIG_CNT_W'(1)) begin
          cell_ctrl.shift_dig = 1'b1;
          ndig_nxt            = ndig_r - 1'b1;
        end else begin
          state_nxt = neg_r ? ST_SIGN : ST_EMIT;
        end
      end

      ST_SIGN: begin
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          ochar_nxt  = CODE_MINUS;
          olast_nxt  = 1'b0;
          state_nxt  = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (slot_free) begin
          ovalid_nxt          = 1'b1;
          ochar_nxt           = CODE_ZERO + CHAR_W'(top_digit);
          olast_nxt           = (ndig_r == DIG_CNT_W'(1));
          cell_ctrl.shift_dig = 1'b1;
          ndig_nxt            = ndig_r - 1'b1;
          if (ndig_r == DIG_CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r   <= mag_nxt;
    neg_r   <= neg_nxt;
    cnt_r   <= cnt_nxt;
    ndig_r  <= ndig_nxt;
    ochar_r <= ochar_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid     = ovalid_r;
  assign out_char_code = ochar_r;
  assign out_last      = olast_r;

  // every character is a minus sign or a decimal digit
  `ASSERT_ALWAYS(a_char_code, clk, rst_n, !out_valid || out_char_code == CODE_MINUS || (out_char_code >= CODE_ZERO && out_char_code <= CODE_NINE), "char code out of range")
  // text never ends on the minus sign
  `ASSERT_ALWAYS(a_last_digit, clk, rst_n, !(out_valid && out_last) || out_char_code != CODE_MINUS, "minus sign flagged last")
  // one item in work at a time: accepting an item closes the input
  `ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready, "input open during conversion")
  // a new item never starts while the digit row still holds unsent digits
  `ASSERT_ALWAYS(a_no_overlap, clk, rst_n, !(in_ready && (state_r == ST_EMIT || state_r == ST_SIGN)), "input open while emitting")

endmodule
